@@ hw/rtl/caic_pkg.sv @@
// Package for the circular angle interval combiner.
// Holds the angle width, the special angle codes and the action codes.
// No dependencies.
package caic_pkg;

   localparam int ANGLE_WIDTH = 32;

   typedef logic [ANGLE_WIDTH-1:0] angle_type;

   localparam angle_type ANGLE_ALL  = '1;
   localparam angle_type ANGLE_ZERO = '0;

   localparam logic ACT_INTERSECT = 1'b0;
   localparam logic ACT_UNION     = 1'b1;

endpackage

@@ hw/rtl/circular_angle_interval_combine.sv @@
// Circular angle interval combiner: intersection or union of two wrapping intervals.
// Depends on caic_pkg for the angle type, special angles and action codes.
// The request is registered in the stage registers, and the result in the response registers that raise the strobe.
// Throughput: one request every cycle; busy stays low, as the receiver cannot stall.
// The rate is set by the single subtract-compare-select pass between the two registers.
// Reset: synchronous, active high; clears both valid flags, so no strobe follows reset.
module circular_angle_interval_combine
   import caic_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   output logic      busy,
   input  logic      req_action,
   input  angle_type req_first_start,
   input  angle_type req_first_end,
   input  angle_type req_second_start,
   input  angle_type req_second_end,
   output logic      rsp_valid,
   output angle_type rsp_out_start,
   output angle_type rsp_out_end,
   output logic      rsp_nonempty
);

   logic      stg_valid_ff;
   logic      stg_action_ff;
   angle_type a_s_ff, a_e_ff, b_s_ff, b_e_ff;

   logic      rsp_valid_ff;
   angle_type rsp_start_ff, rsp_end_ff;
   logic      rsp_ne_ff;

   angle_type rsp_start_in, rsp_end_in;
   logic      rsp_ne_in;

   logic      a_full, b_full, a_empty, b_empty;
   angle_type alen, blen, boff_s, boff_e;
   angle_type lo_end, hi_end;
   logic      lo_zero;

   assign busy = 1'b0;

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff <= 1'b0;
      end else begin
         stg_valid_ff <= start && !busy;
      end
      if (start && !busy) begin
         stg_action_ff <= req_action;
         a_s_ff        <= req_first_start;
         a_e_ff        <= req_first_end;
         b_s_ff        <= req_second_start;
         b_e_ff        <= req_second_end;
      end
   end

   assign a_full  = (a_s_ff == ANGLE_ALL) && (a_e_ff == ANGLE_ALL);
   assign b_full  = (b_s_ff == ANGLE_ALL) && (b_e_ff == ANGLE_ALL);
   assign a_empty = (a_s_ff == a_e_ff) && (a_s_ff != ANGLE_ALL);
   assign b_empty = (b_s_ff == b_e_ff) && (b_s_ff != ANGLE_ALL);

   assign alen   = a_e_ff - a_s_ff;
   assign blen   = b_e_ff - b_s_ff;
   assign boff_s = b_s_ff - a_s_ff;
   assign boff_e = b_e_ff - a_s_ff;

   // rebased ends map back to the original angles, so no adder is needed
   assign lo_end  = (alen < boff_e) ? a_e_ff : b_e_ff;
   assign hi_end  = (alen > boff_e) ? a_e_ff : b_e_ff;
   assign lo_zero = (alen == ANGLE_ZERO) || (boff_e == ANGLE_ZERO);

   always_comb begin
      rsp_start_in = ANGLE_ZERO;
      rsp_end_in   = ANGLE_ZERO;
      rsp_ne_in    = 1'b1;
      case (stg_action_ff)
         ACT_INTERSECT: begin
            if (a_empty || b_empty) begin
               rsp_ne_in = 1'b0;
            end else if (a_full) begin
               rsp_start_in = b_s_ff;
               rsp_end_in   = b_e_ff;
            end else if (b_full) begin
               rsp_start_in = a_s_ff;
               rsp_end_in   = a_e_ff;
            end else if (boff_s <= boff_e) begin
               if (boff_s >= alen) begin
                  rsp_ne_in = 1'b0;
               end else begin
                  rsp_start_in = b_s_ff;
                  rsp_end_in   = lo_end;
               end
            end else if (alen > boff_s) begin
               // two pieces: return the shorter operand, the second on a tie
               if (alen < blen) begin
                  rsp_start_in = a_s_ff;
                  rsp_end_in   = a_e_ff;
               end else begin
                  rsp_start_in = b_s_ff;
                  rsp_end_in   = b_e_ff;
               end
            end else if (lo_zero) begin
               rsp_ne_in = 1'b0;
            end else begin
               rsp_start_in = a_s_ff;
               rsp_end_in   = lo_end;
            end
         end
         ACT_UNION: begin
            if (a_full || b_full) begin
               rsp_start_in = ANGLE_ALL;
               rsp_end_in   = ANGLE_ALL;
            end else if (a_empty) begin
               rsp_start_in = b_s_ff;
               rsp_end_in   = b_e_ff;
            end else if (b_empty) begin
               rsp_start_in = a_s_ff;
               rsp_end_in   = a_e_ff;
            end else if (boff_s < boff_e) begin
               rsp_start_in = a_s_ff;
               rsp_end_in   = hi_end;
            end else if (alen >= boff_s) begin
               rsp_start_in = ANGLE_ALL;
               rsp_end_in   = ANGLE_ALL;
            end else begin
               // bridge the gap that opens at the second start
               rsp_start_in = b_s_ff;
               rsp_end_in   = hi_end;
            end
         end
         default: begin
            rsp_ne_in = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= stg_valid_ff;
      end
      if (stg_valid_ff) begin
         rsp_start_ff <= rsp_start_in;
         rsp_end_ff   <= rsp_end_in;
         rsp_ne_ff    <= rsp_ne_in;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_start = rsp_start_ff;
   assign rsp_out_end   = rsp_end_ff;
   assign rsp_nonempty  = rsp_ne_ff;

`ifndef SYNTHESIS
   a_strobe_follows : assert property (@(posedge clock) disable iff (reset)
      stg_valid_ff |=> rsp_valid_ff)
      else $error("result strobe missing after a staged request");

   a_no_spurious : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> $past(stg_valid_ff))
      else $error("result strobe without a staged request");

   a_empty_zero : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ne_ff) |-> (rsp_start_ff == ANGLE_ZERO && rsp_end_ff == ANGLE_ZERO))
      else $error("empty result not encoded as zero");

   a_union_nonempty : assert property (@(posedge clock) disable iff (reset)
      (stg_valid_ff && stg_action_ff == ACT_UNION) |=> rsp_ne_ff)
      else $error("union result flagged empty");
`endif

endmodule
